/* rtl/atids_pkg.sv */
package atids_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W       = 32;
	localparam int OP_W        = 3;
	localparam int ST_W        = 2;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND  = 3'd0,
		OP_INSERT  = 3'd1,
		OP_DELETE  = 3'd2,
		OP_LSEARCH = 3'd3,
		OP_BSEARCH = 3'd4
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_MISS  = 2'd3
	} st_t;

	// microprogram step addresses
	typedef enum logic [4:0] {
		U_IDLE, U_OK, U_FULL, U_RANGE, U_MISS,
		U_A0, U_A1,
		U_I0, U_I1, U_I2, U_I3, U_I4,
		U_D0, U_D1, U_D2, U_D3,
		U_L0, U_L1, U_L2, U_L3, U_L4,
		U_B0, U_B1, U_B2, U_B3
	} upc_t;

	typedef enum logic [3:0] {
		C_NONE, C_FULL, C_INS_RANGE, C_DEL_RANGE, C_PTR_EQ_POS,
		C_DEL_END, C_PTR_GE_CNT, C_LIN_STOP, C_MATCH, C_LO_GE_HI
	} cond_t;

	typedef enum logic [2:0] {
		P_HOLD, P_CNT, P_POS, P_ZERO, P_DEC, P_INC, P_MID
	} ptr_op_t;

	typedef enum logic [2:0] {
		R_NONE, R_PTR_M1, R_PTR_P1, R_PTR, R_MID
	} rd_t;

	typedef enum logic [1:0] {
		W_NONE, W_AT_CNT, W_AT_POS
	} wr_t;

	typedef enum logic [1:0] {
		N_HOLD, N_INC, N_DEC
	} cnt_op_t;

	typedef enum logic [1:0] {
		B_HOLD, B_INIT, B_NARROW
	} bs_op_t;

	typedef enum logic [1:0] {
		F_HOLD, F_PTR_M1, F_PTR
	} fnd_op_t;

	typedef struct packed {
		ptr_op_t ptr_op;
		rd_t     rd;
		logic    shift;
		wr_t     wr;
		cnt_op_t cnt_op;
		bs_op_t  bs_op;
		fnd_op_t fnd_op;
		logic    emit;
		st_t     st;
	} act_t;

	typedef struct packed {
		logic  dispatch;
		cond_t cond;
		upc_t  jt;
		upc_t  jf;
		act_t  act;
	} ucw_t;

	typedef struct packed {
		logic full;
		logic ins_range;
		logic del_range;
		logic ptr_eq_pos;
		logic del_end;
		logic ptr_ge_cnt;
		logic lin_stop;
		logic match;
		logic lo_ge_hi;
	} flags_t;

	// Control store: a true condition jumps to jt and suppresses the actions,
	// otherwise the actions run and control goes to jf.
	function automatic ucw_t ucode(upc_t a);
		ucw_t w;
		w = '0;
		w.jf = U_IDLE;
		unique case (a)
			U_IDLE: begin
				w.dispatch = 1'b1;
			end
			U_OK: begin
				w.act.emit = 1'b1; w.act.st = ST_OK;
			end
			U_FULL: begin
				w.act.emit = 1'b1; w.act.st = ST_FULL;
			end
			U_RANGE: begin
				w.act.emit = 1'b1; w.act.st = ST_RANGE;
			end
			U_MISS: begin
				w.act.emit = 1'b1; w.act.st = ST_MISS;
			end
			U_A0: begin
				w.cond = C_FULL; w.jt = U_FULL; w.jf = U_A1;
			end
			U_A1: begin
				w.act.wr = W_AT_CNT; w.act.cnt_op = N_INC; w.jf = U_OK;
			end
			U_I0: begin
				w.cond = C_INS_RANGE; w.jt = U_RANGE; w.jf = U_I1;
			end
			U_I1: begin
				w.cond = C_FULL; w.jt = U_FULL; w.jf = U_I2;
			end
			U_I2: begin
				w.act.ptr_op = P_CNT; w.jf = U_I3;
			end
			U_I3: begin
				w.cond = C_PTR_EQ_POS; w.jt = U_I4; w.jf = U_I3;
				w.act.rd = R_PTR_M1; w.act.shift = 1'b1; w.act.ptr_op = P_DEC;
			end
			U_I4: begin
				w.act.wr = W_AT_POS; w.act.cnt_op = N_INC; w.jf = U_OK;
			end
			U_D0: begin
				w.cond = C_DEL_RANGE; w.jt = U_RANGE; w.jf = U_D1;
			end
			U_D1: begin
				w.act.ptr_op = P_POS; w.jf = U_D2;
			end
			U_D2: begin
				w.cond = C_DEL_END; w.jt = U_D3; w.jf = U_D2;
				w.act.rd = R_PTR_P1; w.act.shift = 1'b1; w.act.ptr_op = P_INC;
			end
			U_D3: begin
				w.act.cnt_op = N_DEC; w.jf = U_OK;
			end
			U_L0: begin
				w.act.ptr_op = P_ZERO; w.jf = U_L1;
			end
			U_L1: begin
				w.cond = C_PTR_GE_CNT; w.jt = U_MISS; w.jf = U_L2;
				w.act.rd = R_PTR; w.act.ptr_op = P_INC;
			end
			U_L2: begin
				w.cond = C_LIN_STOP; w.jt = U_L3; w.jf = U_L2;
				w.act.rd = R_PTR; w.act.ptr_op = P_INC;
			end
			U_L3: begin
				w.cond = C_MATCH; w.jt = U_L4; w.jf = U_MISS;
			end
			U_L4: begin
				w.act.fnd_op = F_PTR_M1; w.jf = U_OK;
			end
			U_B0: begin
				w.act.bs_op = B_INIT; w.jf = U_B1;
			end
			U_B1: begin
				w.cond = C_LO_GE_HI; w.jt = U_MISS; w.jf = U_B2;
				w.act.rd = R_MID; w.act.ptr_op = P_MID;
			end
			U_B2: begin
				w.cond = C_MATCH; w.jt = U_B3; w.jf = U_B1;
				w.act.bs_op = B_NARROW;
			end
			U_B3: begin
				w.act.fnd_op = F_PTR; w.jf = U_OK;
			end
			default: begin
				w.jf = U_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

/* rtl/atids_seq.sv */
module atids_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [atids_pkg::OP_W-1:0]   operation,
	input  atids_pkg::flags_t            flags,
	output atids_pkg::act_t              act,
	output logic                         busy
);
	import atids_pkg::*;

	upc_t upc_q;
	upc_t upc_d;
	ucw_t ucw;
	logic hit;

	function automatic upc_t entry(op_t op);
		upc_t e;
		unique case (op)
			OP_APPEND:  e = U_A0;
			OP_INSERT:  e = U_I0;
			OP_DELETE:  e = U_D0;
			OP_LSEARCH: e = U_L0;
			OP_BSEARCH: e = U_B0;
			default:    e = U_OK;
		endcase
		return e;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= U_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

	always_comb begin
		ucw = ucode(upc_q);
		unique case (ucw.cond)
			C_FULL:       hit = flags.full;
			C_INS_RANGE:  hit = flags.ins_range;
			C_DEL_RANGE:  hit = flags.del_range;
			C_PTR_EQ_POS: hit = flags.ptr_eq_pos;
			C_DEL_END:    hit = flags.del_end;
			C_PTR_GE_CNT: hit = flags.ptr_ge_cnt;
			C_LIN_STOP:   hit = flags.lin_stop;
			C_MATCH:      hit = flags.match;
			C_LO_GE_HI:   hit = flags.lo_ge_hi;
			default:      hit = 1'b0;
		endcase
		if (ucw.dispatch) begin
			upc_d = start ? entry(op_t'(operation)) : ucw.jf;
		end else if (hit) begin
			upc_d = ucw.jt;
		end else begin
			upc_d = ucw.jf;
		end
		// drop the actions of a step whose condition takes the jump
		act  = hit ? act_t'('0) : ucw.act;
		busy = (upc_q != U_IDLE);
	end

endmodule

/* rtl/atids_dp.sv */
module atids_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic [atids_pkg::CNT_W-1:0]       position,
	input  logic signed [atids_pkg::KEY_W-1:0] item_value,
	input  logic                              cfg_we,
	input  logic [atids_pkg::CNT_W-1:0]       cfg_data,
	input  atids_pkg::act_t                   act,
	output atids_pkg::flags_t                 flags,
	output logic                              done,
	output logic [atids_pkg::ST_W-1:0]        status,
	output logic [atids_pkg::ADDR_W-1:0]      found_position,
	output logic [atids_pkg::CNT_W-1:0]       element_count
);
	import atids_pkg::*;

	logic signed [KEY_W-1:0] mem [TABLE_DEPTH];

	logic [CNT_W-1:0]        cap_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        pos_q;
	logic signed [KEY_W-1:0] key_q;
	logic [CNT_W-1:0]        ptr_q;
	logic [CNT_W-1:0]        lo_q;
	logic [CNT_W-1:0]        hi_q;
	logic [ADDR_W-1:0]       wb_addr_q;
	logic                    wb_pend_q;
	logic signed [KEY_W-1:0] rdata_q;
	logic [ADDR_W-1:0]       found_q;
	st_t                     status_q;
	logic                    done_q;

	logic [CNT_W-1:0]        limit;
	logic [CNT_W:0]          mid_sum;
	logic [CNT_W-1:0]        mid;
	logic [CNT_W-1:0]        raddr;
	logic                    rd_en;
	logic                    key_lt;
	logic [CNT_W-1:0]        ptr_m1;
	logic [CNT_W-1:0]        ptr_p1;

	always_comb begin
		limit   = (cap_q < CNT_W'(TABLE_DEPTH)) ? cap_q : CNT_W'(TABLE_DEPTH);
		mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - (CNT_W+1)'(1);
		mid     = mid_sum[CNT_W:1];
		ptr_m1  = ptr_q - CNT_W'(1);
		ptr_p1  = ptr_q + CNT_W'(1);
		key_lt  = key_q < rdata_q;
		rd_en   = (act.rd != R_NONE);
		unique case (act.rd)
			R_PTR_M1: raddr = ptr_m1;
			R_PTR_P1: raddr = ptr_p1;
			R_PTR:    raddr = ptr_q;
			R_MID:    raddr = mid;
			default:  raddr = ptr_q;
		endcase
		flags.full       = (cnt_q >= limit);
		flags.ins_range  = (pos_q > cnt_q);
		flags.del_range  = (pos_q >= cnt_q);
		flags.ptr_eq_pos = (ptr_q == pos_q);
		flags.del_end    = (({1'b0, ptr_q} + (CNT_W+1)'(1)) >= {1'b0, cnt_q});
		flags.ptr_ge_cnt = (ptr_q >= cnt_q);
		flags.match      = (rdata_q == key_q);
		flags.lin_stop   = flags.match | flags.ptr_ge_cnt;
		flags.lo_ge_hi   = (lo_q >= hi_q);
	end

	// single write port: a pending shift write-back never meets a key write
	always_ff @(posedge clk) begin
		priority if (wb_pend_q) begin
			mem[wb_addr_q] <= rdata_q;
		end else if (act.wr == W_AT_CNT) begin
			mem[cnt_q[ADDR_W-1:0]] <= key_q;
		end else if (act.wr == W_AT_POS) begin
			mem[pos_q[ADDR_W-1:0]] <= key_q;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= CNT_W'(TABLE_DEPTH);
			cnt_q     <= '0;
			wb_pend_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			unique case (act.cnt_op)
				N_INC:   cnt_q <= cnt_q + CNT_W'(1);
				N_DEC:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
			wb_pend_q <= act.shift;
			done_q    <= act.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q   <= position;
			key_q   <= item_value;
			found_q <= '0;
		end else begin
			unique case (act.fnd_op)
				F_PTR_M1: found_q <= ptr_m1[ADDR_W-1:0];
				F_PTR:    found_q <= ptr_q[ADDR_W-1:0];
				default:  found_q <= found_q;
			endcase
		end
		if (act.shift) begin
			wb_addr_q <= ptr_q[ADDR_W-1:0];
		end
		unique case (act.ptr_op)
			P_CNT:   ptr_q <= cnt_q;
			P_POS:   ptr_q <= pos_q;
			P_ZERO:  ptr_q <= '0;
			P_DEC:   ptr_q <= ptr_m1;
			P_INC:   ptr_q <= ptr_p1;
			P_MID:   ptr_q <= mid;
			default: ptr_q <= ptr_q;
		endcase
		unique case (act.bs_op)
			B_INIT: begin
				lo_q <= '0;
				hi_q <= cnt_q;
			end
			B_NARROW: begin
				if (key_lt) begin
					hi_q <= ptr_q;
				end else begin
					lo_q <= ptr_p1;
				end
			end
			default: begin
				lo_q <= lo_q;
			end
		endcase
		if (act.emit) begin
			status_q <= act.st;
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign found_position = found_q;
	assign element_count  = cnt_q;

endmodule

/* rtl/array_table_insert_delete_search_top.sv */
// Packed table of up to 256 signed 32-bit words with a length, driven one
// command word at a time: append, insert at an index, delete at an index,
// linear search for the first match, and binary search over contents taken
// as sorted ascending. Raise start with the operation, position and
// item_value fields; the word is taken on an edge where busy is low, and busy
// then stays high until the result is out. Every command gives exactly one
// result word, shown for a single cycle with done high: status, found index
// (zero unless a search hit) and the element count after the command. There
// is no backpressure on the result side, so sample it on that cycle. The cost
// of a command is set by the table's single memory, whose one read and one
// write port move or compare one entry per cycle.
// A short control store steps each command through a shared datapath. The
// capacity register (reset 256, 9 bits) may be written through the cfg
// channel, which is always ready; write it only while the block is idle.
// Lowering it below the count keeps the stored words but makes append and
// insert report full. There is no clearing pass after reset: entries are only
// ever read below the count, so their power-up contents never show.
module array_table_insert_delete_search_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [atids_pkg::OP_W-1:0]         operation,
	input  logic [atids_pkg::CNT_W-1:0]        position,
	input  logic signed [atids_pkg::KEY_W-1:0] item_value,
	output logic                               done,
	output logic [atids_pkg::ST_W-1:0]         status,
	output logic [atids_pkg::ADDR_W-1:0]       found_position,
	output logic [atids_pkg::CNT_W-1:0]        element_count,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [atids_pkg::CNT_W-1:0]        cfg_data
);
	import atids_pkg::*;

	act_t   act;
	flags_t flags;
	logic   accept;

	// take a command word whenever the sequencer sits at its idle step
	assign accept    = start & ~busy;
	// hold the capacity register open for writes at all times
	assign cfg_ready = 1'b1;

	atids_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.flags     (flags),
		.act       (act),
		.busy      (busy)
	);

	atids_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.position       (position),
		.item_value     (item_value),
		.cfg_we         (cfg_valid & cfg_ready),
		.cfg_data       (cfg_data),
		.act            (act),
		.flags          (flags),
		.done           (done),
		.status         (status),
		.found_position (found_position),
		.element_count  (element_count)
	);

endmodule

/* rtl/atids_chk.sv */
module atids_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic                               done,
	input logic [atids_pkg::ST_W-1:0]         status,
	input logic [atids_pkg::ADDR_W-1:0]       found_position,
	input logic [atids_pkg::CNT_W-1:0]        element_count
);
	import atids_pkg::*;

	// an accepted command word always leaves the idle step
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	// the result goes out as the sequencer returns to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	// one result per command: never two strobes in a row
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	// a miss or a rejected command reports index zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_MISS || status == ST_FULL || status == ST_RANGE)
		|-> found_position == '0)
		else $error("non-zero index on a result that found nothing");

	// the count never exceeds the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		element_count <= CNT_W'(TABLE_DEPTH))
		else $error("element count beyond table depth");

endmodule

bind array_table_insert_delete_search_top atids_chk u_chk (.*);

/* bench/tb_array_table_insert_delete_search_top.sv */
`timescale 1ns / 100ps

module tb_array_table_insert_delete_search_top;
	import atids_pkg::*;

	// Codes 5 to 7 are not in op_t; the block must treat them as no-ops.
	localparam logic [OP_W-1:0]  OP_SPARE_LO = 3'd5;
	localparam logic [OP_W-1:0]  OP_SPARE_HI = 3'd7;
	localparam logic [CNT_W-1:0] POS_MAX     = '1;
	localparam logic [CNT_W-1:0] CAP_MAX     = '1;
	localparam logic signed [KEY_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [KEY_W-1:0] WORD_MAX = 32'sh7fff_ffff;
	// Fixed end of run; the slowest legal run stays well inside it.
	localparam int LIMIT_NS = 40_000_000;

	typedef struct {
		st_t              st;
		logic [ADDR_W-1:0] fpos;
		logic [CNT_W-1:0]  cnt;
	} reply_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [OP_W-1:0] operation;
	logic [CNT_W-1:0] position;
	logic signed [KEY_W-1:0] item_value;
	logic done;
	logic [ST_W-1:0] status;
	logic [ADDR_W-1:0] found_position;
	logic [CNT_W-1:0] element_count;
	logic cfg_valid;
	logic cfg_ready;
	logic [CNT_W-1:0] cfg_data;

	// Shadow copy of the table, its length and the capacity register.
	logic signed [KEY_W-1:0] shadow_words [TABLE_DEPTH];
	int shadow_count = 0;
	int shadow_cap = 256;

	// Result words still to come, oldest first.
	reply_t replies_due [$];
	int mismatches = 0;
	// Set to run a stretch of commands back to back.
	bit no_idle = 1'b0;

	array_table_insert_delete_search_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.position       (position),
		.item_value     (item_value),
		.done           (done),
		.status         (status),
		.found_position (found_position),
		.element_count  (element_count),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

	// Apply one command to the shadow table and return the word it must give.
	function automatic reply_t apply_command(input logic [OP_W-1:0] op,
			input logic [CNT_W-1:0] pos, input logic signed [KEY_W-1:0] key);
		reply_t r;
		int n;
		int lim;
		int lo;
		int hi;
		int mid;
		int i;
		r.st = ST_OK;
		r.fpos = '0;
		n = shadow_count;
		lim = (shadow_cap < TABLE_DEPTH) ? shadow_cap : TABLE_DEPTH;
		case (op)
			OP_APPEND: begin
				if (n >= lim) begin
					r.st = ST_FULL;
				end else begin
					shadow_words[n] = key;
					n++;
				end
			end
			OP_INSERT: begin
				// Range is checked ahead of full.
				if (int'(pos) > n) begin
					r.st = ST_RANGE;
				end else if (n >= lim) begin
					r.st = ST_FULL;
				end else begin
					for (i = n; i > int'(pos); i--)
						shadow_words[i] = shadow_words[i-1];
					shadow_words[pos] = key;
					n++;
				end
			end
			OP_DELETE: begin
				if (int'(pos) >= n) begin
					r.st = ST_RANGE;
				end else begin
					for (i = int'(pos); i + 1 < n; i++)
						shadow_words[i] = shadow_words[i+1];
					n--;
				end
			end
			OP_LSEARCH: begin
				r.st = ST_MISS;
				for (i = 0; i < n; i++) begin
					if (shadow_words[i] == key) begin
						r.st = ST_OK;
						r.fpos = i[ADDR_W-1:0];
						break;
					end
				end
			end
			OP_BSEARCH: begin
				// Plain halving over [lo, hi); unsorted contents give whatever it lands on.
				r.st = ST_MISS;
				lo = 0;
				hi = n;
				while (lo < hi) begin
					mid = (lo + hi - 1) / 2;
					if (shadow_words[mid] == key) begin
						r.st = ST_OK;
						r.fpos = mid[ADDR_W-1:0];
						break;
					end else if (key < shadow_words[mid]) begin
						hi = mid;
					end else begin
						lo = mid + 1;
					end
				end
			end
			default: begin
			end
		endcase
		shadow_count = n;
		r.cnt = n[CNT_W-1:0];
		return r;
	endfunction

	function automatic logic signed [KEY_W-1:0] rand_word();
		case ($urandom_range(0, 9))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2, 3: return $signed(KEY_W'($urandom_range(0, 8))) - 4;
			default: return $signed($urandom);
		endcase
	endfunction

	task automatic flag_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Present one command word and hold it until the block takes it.
	// Start is only lowered when a gap follows, so a back-to-back word never
	// sees start dropped and raised in the same step.
	task automatic issue_cmd(input logic [OP_W-1:0] op, input logic [CNT_W-1:0] pos,
			input logic signed [KEY_W-1:0] key);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		position <= pos;
		item_value <= key;
		@(posedge clk);
		while (busy) @(posedge clk);
		replies_due.push_back(apply_command(op, pos, key));
	endtask

	// Drop start and hold until every pending result word has come back.
	task automatic settle_idle();
		start <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Only called while idle.
	task automatic write_capacity(input logic [CNT_W-1:0] cap);
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		shadow_cap = cap;
	endtask

	// Delete at random valid positions until the table is empty.
	task automatic empty_table();
		while (shadow_count > 0)
			issue_cmd(OP_DELETE, CNT_W'($urandom_range(0, shadow_count - 1)), rand_word());
	endtask

	// Result checker: a result word is only on the ports for one cycle, so
	// take it at the edge that closes that cycle.
	reply_t want;
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (replies_due.size() == 0) begin
				flag_mismatch("result word with nothing pending");
			end else begin
				want = replies_due.pop_front();
				if (status !== want.st)
					flag_mismatch($sformatf("status %0d, want %0d", status, want.st));
				if (found_position !== want.fpos)
					flag_mismatch($sformatf("found_position %0d, want %0d",
						found_position, want.fpos));
				if (element_count !== want.cnt)
					flag_mismatch($sformatf("element_count %0d, want %0d",
						element_count, want.cnt));
			end
		end
	end

	// Empty-table misses, range errors, duplicates, the word extremes, an
	// unsorted binary search and the spare op codes.
	task automatic test_basic_ops();
		issue_cmd(OP_LSEARCH, '0, 32'sd0);
		issue_cmd(OP_BSEARCH, '0, 32'sd0);
		issue_cmd(OP_DELETE, '0, 32'sd0);
		issue_cmd(OP_INSERT, 9'd1, 32'sd0);
		issue_cmd(OP_INSERT, '0, WORD_MAX);
		issue_cmd(OP_APPEND, '0, WORD_MIN);
		issue_cmd(OP_APPEND, POS_MAX, 32'sd0);
		issue_cmd(OP_APPEND, '0, -32'sd1);
		// insert at the very end, then a duplicate in the middle
		issue_cmd(OP_INSERT, 9'd4, 32'sd5);
		issue_cmd(OP_INSERT, 9'd2, 32'sd5);
		issue_cmd(OP_INSERT, 9'd256, 32'sd9);
		issue_cmd(OP_INSERT, POS_MAX, 32'sd9);
		issue_cmd(OP_DELETE, 9'd6, 32'sd0);
		issue_cmd(OP_DELETE, 9'd5, 32'sd0);
		issue_cmd(OP_DELETE, '0, 32'sd0);
		issue_cmd(OP_LSEARCH, '0, 32'sd5);
		issue_cmd(OP_LSEARCH, POS_MAX, 32'sd12345);
		issue_cmd(OP_LSEARCH, '0, WORD_MIN);
		issue_cmd(OP_BSEARCH, '0, 32'sd0);
		issue_cmd(OP_BSEARCH, '0, -32'sd1);
		for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++)
			issue_cmd(OP_W'(c), POS_MAX, $signed($urandom));
		issue_cmd(OP_DELETE, POS_MAX, 32'sd0);
	endtask

	// Capacity below the count: append and insert report full, range still
	// wins over full, delete and the searches carry on.
	task automatic test_capacity_limits();
		settle_idle();
		write_capacity(9'd2);
		issue_cmd(OP_APPEND, '0, 32'sd1);
		issue_cmd(OP_INSERT, '0, 32'sd1);
		issue_cmd(OP_INSERT, CNT_W'(shadow_count + 1), 32'sd1);
		issue_cmd(OP_DELETE, '0, 32'sd0);
		issue_cmd(OP_LSEARCH, '0, -32'sd1);
		issue_cmd(OP_BSEARCH, '0, 32'sd5);
		settle_idle();
		write_capacity(CNT_W'(shadow_count));
		issue_cmd(OP_APPEND, '0, 32'sd2);
		settle_idle();
		write_capacity('0);
		issue_cmd(OP_INSERT, '0, 32'sd3);
		issue_cmd(OP_DELETE, '0, 32'sd0);
		settle_idle();
		// all ones: the limit in force is the table depth
		write_capacity(CAP_MAX);
		issue_cmd(OP_APPEND, '0, 32'sd4);
		issue_cmd(OP_INSERT, CNT_W'(shadow_count), 32'sd6);
	endtask

	// Fill all 256 entries with ascending words, then hit the far end.
	task automatic test_fill_to_depth();
		settle_idle();
		write_capacity(9'd256);
		no_idle = 1'b1;
		while (shadow_count > 0)
			issue_cmd(OP_DELETE, CNT_W'(shadow_count - 1), 32'sd0);
		no_idle = 1'b0;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			no_idle = (k >= 64 && k < 192);
			issue_cmd(OP_APPEND, '0, KEY_W'(k * 4099 - 500000));
		end
		no_idle = 1'b0;
		issue_cmd(OP_APPEND, '0, 32'sd1);
		issue_cmd(OP_INSERT, 9'd256, 32'sd1);
		issue_cmd(OP_INSERT, 9'd257, 32'sd1);
		issue_cmd(OP_LSEARCH, '0, shadow_words[TABLE_DEPTH-1]);
		issue_cmd(OP_BSEARCH, '0, shadow_words[TABLE_DEPTH-1]);
		issue_cmd(OP_BSEARCH, '0, shadow_words[0]);
		issue_cmd(OP_BSEARCH, '0, shadow_words[100]);
		issue_cmd(OP_BSEARCH, '0, shadow_words[100] + 1);
		issue_cmd(OP_DELETE, 9'd255, 32'sd0);
		issue_cmd(OP_INSERT, '0, WORD_MIN);
		issue_cmd(OP_BSEARCH, '0, WORD_MIN);
		issue_cmd(OP_DELETE, '0, 32'sd0);
		// shrink cheaply from the end before the random traffic
		while (shadow_count > 24)
			issue_cmd(OP_DELETE, CNT_W'(shadow_count - 1), 32'sd0);
	endtask

	// Random traffic in phases. Each phase picks a capacity and a mode; in
	// sorted mode inserts go to their ordered slot so binary search hits.
	task automatic test_random_traffic();
		bit sorted;
		int n;
		int pick;
		int slot;
		logic [OP_W-1:0] op;
		logic [CNT_W-1:0] pos;
		logic signed [KEY_W-1:0] key;
		for (int phase = 0; phase < 12; phase++) begin
			settle_idle();
			case ($urandom_range(0, 4))
				0: write_capacity(9'd256);
				1: write_capacity(CAP_MAX);
				2: write_capacity(CNT_W'($urandom_range(0, 16)));
				3: write_capacity(CNT_W'($urandom_range(17, 255)));
				default: write_capacity(CNT_W'($urandom_range(257, 511)));
			endcase
			sorted = $urandom_range(0, 1);
			if (sorted)
				empty_table();
			for (int k = 0; k < 75; k++) begin
				// run the odd stretch back to back
				if (k % 25 == 0)
					no_idle = ($urandom_range(0, 3) == 0);
				n = shadow_count;
				pick = $urandom_range(0, 99);
				// lean towards delete when the table grows, to bound the cost
				if (n > 80 && pick < 60)
					pick = 45;
				key = rand_word();
				pos = CNT_W'($urandom_range(0, n));
				if (pick < 20) begin
					op = OP_APPEND;
					if (sorted && n > 0)
						key = $urandom_range(0, 1) ? shadow_words[n-1] : WORD_MAX;
				end else if (pick < 40) begin
					op = OP_INSERT;
					if (sorted) begin
						for (slot = 0; slot < n && shadow_words[slot] <= key; slot++);
						pos = CNT_W'(slot);
					end
					if ($urandom_range(0, 9) == 0)
						pos = CNT_W'($urandom_range(n + 1, POS_MAX));
				end else if (pick < 60) begin
					op = OP_DELETE;
					if (n > 0 && $urandom_range(0, 9) != 0)
						pos = CNT_W'($urandom_range(0, n - 1));
					else
						pos = CNT_W'($urandom_range(n, POS_MAX));
				end else if (pick < 95) begin
					op = (pick < 78) ? OP_LSEARCH : OP_BSEARCH;
					pos = CNT_W'($urandom_range(0, POS_MAX));
					if (n > 0 && $urandom_range(0, 2) != 0)
						key = shadow_words[$urandom_range(0, n - 1)];
				end else begin
					op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
					pos = CNT_W'($urandom_range(0, POS_MAX));
				end
				issue_cmd(op, pos, key);
			end
			no_idle = 1'b0;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_APPEND;
		position = '0;
		item_value = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_capacity_limits();
		test_fill_to_depth();
		test_random_traffic();
		settle_idle();
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
